// ===== hdl/zdf_pkg.sv =====
package zdf_pkg;

    localparam int STAGES       = 4;
    localparam int CHANNELS_DEF = 2;
    localparam int SLOT_W       = $clog2(STAGES);

    localparam int SAMPLE_W   = 24;
    localparam int STATE_W    = 32;
    localparam int COEF_W     = 24;
    localparam int NORM_W     = 25;
    localparam int GAIN_W     = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;

    // quotient bits of the tanh divide, q <= 1.0 in Q4.28
    localparam int DIV_BITS = 29;
    localparam int CNT_W    = $clog2(DIV_BITS);

    typedef logic signed [PROD_W-1:0] wide_t;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_G      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIG_G  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAKEUP = 3'd5;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAT_LP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SAT_HP = 2'd2;

    localparam logic [MODE_W-1:0] RST_MODE   = MODE_SAT_LP;
    localparam logic [COEF_W-1:0] RST_G      = 24'd104858;
    localparam logic [COEF_W-1:0] RST_BIG_G  = 24'd1525201;
    localparam logic [COEF_W-1:0] RST_RES    = 24'd0;
    localparam logic [NORM_W-1:0] RST_NORM   = 25'd16777216;
    localparam logic [GAIN_W-1:0] RST_MAKEUP = 16'd25844;

    localparam logic signed [STATE_W-1:0] ONE_Q28    = 32'sh1000_0000;
    localparam logic [STATE_W-1:0]        CLIP_LIMIT = 32'h3000_0000;
    localparam logic [34:0]               PADE_C27   = 35'h1_B000_0000;

    localparam wide_t S32_MAX = 66'sd2147483647;
    localparam wide_t S32_MIN = -66'sd2147483648;
    localparam wide_t S24_MAX = 66'sd8388607;
    localparam wide_t S24_MIN = -66'sd8388608;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_LOAD,
        OP_H_MUL,
        OP_H_ADD,
        OP_K_MUL,
        OP_K_SUB,
        OP_N_MUL,
        OP_N_RND,
        OP_C_ABS,
        OP_C_SQ,
        OP_C_A2,
        OP_C_MUL,
        OP_C_NUM,
        OP_C_DIV,
        OP_C_SIGN,
        OP_S_DIF,
        OP_S_MUL,
        OP_S_V,
        OP_S_LP,
        OP_S_UPD,
        OP_O_MUL,
        OP_O_RND,
        OP_O_ZERO,
        OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [SLOT_W-1:0] stage;
        logic              hp;
    } dp_cmd_t;

    typedef struct packed {
        logic chan_ok;
        logic clip_big;
    } dp_status_t;

    function automatic logic signed [STATE_W-1:0] sat32(input wide_t x);
        if (x > S32_MAX)
            return S32_MAX[STATE_W-1:0];
        else if (x < S32_MIN)
            return S32_MIN[STATE_W-1:0];
        else
            return x[STATE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input wide_t x);
        if (x > S24_MAX)
            return S24_MAX[SAMPLE_W-1:0];
        else if (x < S24_MIN)
            return S24_MIN[SAMPLE_W-1:0];
        else
            return x[SAMPLE_W-1:0];
    endfunction

    // round half up, then floor shift
    function automatic wide_t rnd_shift(input wide_t x, input int n);
        return (x + (wide_t'(1) <<< (n - 1))) >>> n;
    endfunction

endpackage

// ===== hdl/zdf_ladder_filter_stereo.sv =====
// Four-pole zero-delay-feedback ladder filter, time-shared over the channels.
// Each request carries one Q1.23 sample and a channel number; one saturated
// Q1.23 sample comes back per request, in order. All multiplications run
// through one 33x33 multiplier driven by a sequencer, and no new request is
// taken until the sequencer is back in idle. The saturating modes set u to
// +-1.0 when |u| >= 3.0 and otherwise pass it through a tanh approximation
// with a bit-serial divider. A channel number at or above CHANNELS returns
// zero and leaves the states alone. A stalled result holds the sequencer in
// its last state only while the output register is still occupied. Results
// wait in an output register, so the next request is taken while a result is
// still stalled. Coefficients are loaded by software (g, G, k and the
// precomputed 1/(1+k*g^4)) and may be written only while the filter is idle.
module zdf_ladder_filter_stereo #(
    parameter int CHANNELS = zdf_pkg::CHANNELS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [zdf_pkg::SAMPLE_W-1:0]    sample_in,
    input  logic                                   chan,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [zdf_pkg::SAMPLE_W-1:0]    sample_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [zdf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [zdf_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import zdf_pkg::*;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [COEF_W-1:0] g_reg, g_next;
    logic [COEF_W-1:0] big_g_reg, big_g_next;
    logic [COEF_W-1:0] res_reg, res_next;
    logic [NORM_W-1:0] norm_reg, norm_next;
    logic [GAIN_W-1:0] makeup_reg, makeup_next;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next   = mode_reg;
        g_next      = g_reg;
        big_g_next  = big_g_reg;
        res_next    = res_reg;
        norm_next   = norm_reg;
        makeup_next = makeup_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_next   = cfg_data[MODE_W-1:0];
                REG_G:      g_next      = cfg_data[COEF_W-1:0];
                REG_BIG_G:  big_g_next  = cfg_data[COEF_W-1:0];
                REG_RES:    res_next    = cfg_data[COEF_W-1:0];
                REG_NORM:   norm_next   = cfg_data[NORM_W-1:0];
                REG_MAKEUP: makeup_next = cfg_data[GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= RST_MODE;
            g_reg      <= RST_G;
            big_g_reg  <= RST_BIG_G;
            res_reg    <= RST_RES;
            norm_reg   <= RST_NORM;
            makeup_reg <= RST_MAKEUP;
        end
        else
        begin
            mode_reg   <= mode_next;
            g_reg      <= g_next;
            big_g_reg  <= big_g_next;
            res_reg    <= res_next;
            norm_reg   <= norm_next;
            makeup_reg <= makeup_next;
        end
    end

    zdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mode      (mode_reg),
        .status    (status),
        .cmd       (cmd)
    );

    zdf_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample_in     (sample_in),
        .chan          (chan),
        .coef_g        (g_reg),
        .coef_big_g    (big_g_reg),
        .resonance     (res_reg),
        .feedback_norm (norm_reg),
        .makeup_gain   (makeup_reg),
        .sample_out    (sample_out)
    );

endmodule

// ===== hdl/zdf_ctrl.sv =====
module zdf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  logic [zdf_pkg::MODE_W-1:0] mode,
    input  zdf_pkg::dp_status_t  status,
    output zdf_pkg::dp_cmd_t     cmd
);
    import zdf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHK,
        ST_LOAD,
        ST_H_MUL,
        ST_H_ADD,
        ST_K_MUL,
        ST_K_SUB,
        ST_N_MUL,
        ST_N_RND,
        ST_C_ABS,
        ST_C_SQ,
        ST_C_A2,
        ST_C_MUL,
        ST_C_NUM,
        ST_C_DIV,
        ST_C_SIGN,
        ST_S_DIF,
        ST_S_MUL,
        ST_S_V,
        ST_S_LP,
        ST_S_UPD,
        ST_O_MUL,
        ST_O_RND,
        ST_O_ZERO,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] stage_reg, stage_next;
    logic [CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic              out_valid_reg, out_valid_next;

    logic use_clip;
    logic is_hp;
    logic out_free;

    assign use_clip  = (mode == MODE_SAT_LP) || (mode == MODE_SAT_HP);
    assign is_hp     = (mode == MODE_SAT_HP);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        stage_next     = stage_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        cmd.stage      = stage_reg;
        cmd.hp         = is_hp;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_START;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
                state_next = status.chan_ok ? ST_LOAD : ST_O_ZERO;
            ST_LOAD:
            begin
                cmd.op     = OP_LOAD;
                cmd.stage  = '0;
                stage_next = SLOT_W'(1);
                state_next = ST_H_MUL;
            end
            ST_H_MUL:
            begin
                cmd.op     = OP_H_MUL;
                state_next = ST_H_ADD;
            end
            ST_H_ADD:
            begin
                cmd.op = OP_H_ADD;
                if (stage_reg == SLOT_W'(STAGES - 1))
                begin
                    stage_next = '0;
                    state_next = ST_K_MUL;
                end
                else
                begin
                    stage_next = stage_reg + SLOT_W'(1);
                    state_next = ST_H_MUL;
                end
            end
            ST_K_MUL:
            begin
                cmd.op     = OP_K_MUL;
                state_next = ST_K_SUB;
            end
            ST_K_SUB:
            begin
                cmd.op     = OP_K_SUB;
                state_next = ST_N_MUL;
            end
            ST_N_MUL:
            begin
                cmd.op     = OP_N_MUL;
                state_next = ST_N_RND;
            end
            ST_N_RND:
            begin
                cmd.op     = OP_N_RND;
                state_next = use_clip ? ST_C_ABS : ST_S_DIF;
            end
            ST_C_ABS:
            begin
                cmd.op     = OP_C_ABS;
                state_next = status.clip_big ? ST_S_DIF : ST_C_SQ;
            end
            ST_C_SQ:
            begin
                cmd.op     = OP_C_SQ;
                state_next = ST_C_A2;
            end
            ST_C_A2:
            begin
                cmd.op     = OP_C_A2;
                state_next = ST_C_MUL;
            end
            ST_C_MUL:
            begin
                cmd.op     = OP_C_MUL;
                state_next = ST_C_NUM;
            end
            ST_C_NUM:
            begin
                cmd.op       = OP_C_NUM;
                div_cnt_next = CNT_W'(DIV_BITS - 1);
                state_next   = ST_C_DIV;
            end
            ST_C_DIV:
            begin
                cmd.op = OP_C_DIV;
                if (div_cnt_reg == '0)
                    state_next = ST_C_SIGN;
                else
                    div_cnt_next = div_cnt_reg - CNT_W'(1);
            end
            ST_C_SIGN:
            begin
                cmd.op     = OP_C_SIGN;
                state_next = ST_S_DIF;
            end
            ST_S_DIF:
            begin
                cmd.op     = OP_S_DIF;
                state_next = ST_S_MUL;
            end
            ST_S_MUL:
            begin
                cmd.op     = OP_S_MUL;
                state_next = ST_S_V;
            end
            ST_S_V:
            begin
                cmd.op     = OP_S_V;
                state_next = ST_S_LP;
            end
            ST_S_LP:
            begin
                cmd.op     = OP_S_LP;
                state_next = ST_S_UPD;
            end
            ST_S_UPD:
            begin
                cmd.op = OP_S_UPD;
                if (stage_reg == SLOT_W'(STAGES - 1))
                begin
                    stage_next = '0;
                    state_next = ST_O_MUL;
                end
                else
                begin
                    stage_next = stage_reg + SLOT_W'(1);
                    state_next = ST_S_DIF;
                end
            end
            ST_O_MUL:
            begin
                cmd.op     = OP_O_MUL;
                state_next = ST_O_RND;
            end
            ST_O_RND:
            begin
                cmd.op     = OP_O_RND;
                state_next = ST_FIN;
            end
            ST_O_ZERO:
            begin
                cmd.op     = OP_O_ZERO;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hand over only when the output register is free or draining
                if (out_free)
                begin
                    cmd.op         = OP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stage_reg     <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/zdf_datapath.sv =====
module zdf_datapath #(
    parameter int CHANNELS = zdf_pkg::CHANNELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  zdf_pkg::dp_cmd_t                     cmd,
    output zdf_pkg::dp_status_t                  status,
    input  logic signed [zdf_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic                                 chan,
    input  logic [zdf_pkg::COEF_W-1:0]           coef_g,
    input  logic [zdf_pkg::COEF_W-1:0]           coef_big_g,
    input  logic [zdf_pkg::COEF_W-1:0]           resonance,
    input  logic [zdf_pkg::NORM_W-1:0]           feedback_norm,
    input  logic [zdf_pkg::GAIN_W-1:0]           makeup_gain,
    output logic signed [zdf_pkg::SAMPLE_W-1:0] sample_out
);
    import zdf_pkg::*;

    localparam int DEPTH = CHANNELS * STAGES;
    localparam int AW    = $clog2(DEPTH);

    logic signed [STATE_W-1:0] st_reg [DEPTH];

    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic                       chan_reg, chan_next;
    logic signed [STATE_W-1:0]  acc_reg, acc_next;
    logic signed [STATE_W-1:0]  u_reg, u_next;
    logic signed [STATE_W-1:0]  lp_reg, lp_next;
    logic signed [STATE_W-1:0]  hp_reg, hp_next;
    logic signed [STATE_W-1:0]  v_reg, v_next;
    logic [STATE_W-1:0]         a_reg, a_next;
    logic [STATE_W-1:0]         a2_reg, a2_next;
    logic [63:0]                rem_reg, rem_next;
    logic [62:0]                dsh_reg, dsh_next;
    logic [DIV_BITS-1:0]        q_reg, q_next;
    wide_t                      prod_reg, prod_next;
    logic signed [SAMPLE_W-1:0] res_reg, res_next;
    logic signed [SAMPLE_W-1:0] out_reg, out_next;

    logic [AW-1:0]             addr;
    logic signed [STATE_W-1:0] s_rd;
    logic [STATE_W-1:0]        u_bits;
    logic [STATE_W-1:0]        u_abs;
    logic signed [STATE_W-1:0] src;
    logic signed [STATE_W-1:0] q_pos;
    logic [34:0]               den;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic                      prod_load;
    logic                      st_we;
    logic signed [STATE_W-1:0] st_wdata;

    assign addr   = AW'(int'(chan_reg) * STAGES + int'(cmd.stage));
    assign s_rd   = st_reg[addr];
    assign u_bits = u_reg;
    assign u_abs  = u_bits[STATE_W-1] ? (~u_bits + 32'd1) : u_bits;
    assign src    = cmd.hp ? hp_reg : lp_reg;
    assign q_pos  = {3'b000, q_reg};
    // 27 + 9*a^2, in unsigned Q7.28
    assign den    = PADE_C27 + 35'(a2_reg) * 35'd9;

    assign status.chan_ok  = int'(chan_reg) < CHANNELS;
    assign status.clip_big = (u_abs >= CLIP_LIMIT);

    assign sample_out = out_reg;

    // shared multiplier operands
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        prod_load = 1'b1;
        unique case (cmd.op)
            OP_H_MUL:
            begin
                mul_a = {acc_reg[STATE_W-1], acc_reg};
                mul_b = {9'b0, coef_g};
            end
            OP_K_MUL:
            begin
                mul_a = {acc_reg[STATE_W-1], acc_reg};
                mul_b = {9'b0, resonance};
            end
            OP_N_MUL:
            begin
                mul_a = {u_reg[STATE_W-1], u_reg};
                mul_b = {8'b0, feedback_norm};
            end
            OP_C_SQ:
            begin
                mul_a = {1'b0, a_reg};
                mul_b = {1'b0, a_reg};
            end
            OP_C_MUL:
            begin
                mul_a = {1'b0, a_reg};
                mul_b = {1'b0, a2_reg};
            end
            OP_S_MUL:
            begin
                mul_a = {acc_reg[STATE_W-1], acc_reg};
                mul_b = {9'b0, coef_big_g};
            end
            OP_O_MUL:
            begin
                mul_a = {src[STATE_W-1], src};
                mul_b = {17'b0, makeup_gain};
            end
            default:
                prod_load = 1'b0;
        endcase
    end

    assign prod_next = prod_load ? (wide_t'(mul_a) * wide_t'(mul_b)) : prod_reg;

    always_comb
    begin
        x_next   = x_reg;
        chan_next = chan_reg;
        acc_next = acc_reg;
        u_next   = u_reg;
        lp_next  = lp_reg;
        hp_next  = hp_reg;
        v_next   = v_reg;
        a_next   = a_reg;
        a2_next  = a2_reg;
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        res_next = res_reg;
        out_next = out_reg;
        st_we    = 1'b0;
        st_wdata = sat32(wide_t'(lp_reg) + wide_t'(v_reg));

        unique case (cmd.op)
            OP_START:
            begin
                x_next    = sample_in;
                chan_next = chan;
            end
            OP_LOAD:
                acc_next = s_rd;
            OP_H_ADD:
                acc_next = sat32(rnd_shift(prod_reg, 20) + wide_t'(s_rd));
            OP_K_SUB:
            begin
                u_next = sat32((wide_t'(x_reg) <<< 5) - rnd_shift(prod_reg, 21));
            end
            OP_N_RND:
            begin
                u_next  = sat32(rnd_shift(prod_reg, 24));
                lp_next = u_next;
                hp_next = u_next;
            end
            OP_C_ABS:
            begin
                if (status.clip_big)
                begin
                    u_next  = u_reg[STATE_W-1] ? -ONE_Q28 : ONE_Q28;
                    lp_next = u_next;
                    hp_next = u_next;
                end
                else
                    a_next = u_abs;
            end
            OP_C_A2:
                a2_next = prod_reg[59:28];
            OP_C_NUM:
            begin
                // a*(27 + a^2) = a*a^2 + 27*a, in Q8.56
                rem_next = prod_reg[63:0] + ((64'(a_reg) * 64'd27) << 28);
                dsh_next = {den, 28'b0};
                q_next   = '0;
            end
            OP_C_DIV:
            begin
                if ({1'b0, dsh_reg} <= rem_reg)
                begin
                    rem_next = rem_reg - {1'b0, dsh_reg};
                    q_next   = {q_reg[DIV_BITS-2:0], 1'b1};
                end
                else
                    q_next = {q_reg[DIV_BITS-2:0], 1'b0};
                dsh_next = dsh_reg >> 1;
            end
            OP_C_SIGN:
            begin
                u_next  = u_reg[STATE_W-1] ? -q_pos : q_pos;
                lp_next = u_next;
                hp_next = u_next;
            end
            OP_S_DIF:
                acc_next = sat32(wide_t'(src) - wide_t'(s_rd));
            OP_S_V:
                v_next = sat32(rnd_shift(prod_reg, 24));
            OP_S_LP:
                lp_next = sat32(wide_t'(v_reg) + wide_t'(s_rd));
            OP_S_UPD:
            begin
                st_we   = 1'b1;
                hp_next = sat32(wide_t'(hp_reg) - wide_t'(lp_reg));
            end
            OP_O_RND:
                res_next = sat24(rnd_shift(prod_reg, 17));
            OP_O_ZERO:
                res_next = '0;
            OP_OUT_LOAD:
                out_next = res_reg;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        chan_reg <= chan_next;
        acc_reg  <= acc_next;
        u_reg    <= u_next;
        lp_reg   <= lp_next;
        hp_reg   <= hp_next;
        v_reg    <= v_next;
        a_reg    <= a_next;
        a2_reg   <= a2_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // integrator states, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                st_reg[i] <= '0;
        end
        else if (st_we)
        begin
            st_reg[addr] <= st_wdata;
        end
    end

endmodule
